// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_ctrl, ple_datapath and the core top level.
package ple_pkg;

    // List capacity and derived widths
    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;

    // Request opcodes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_REM_FRONT = 3'd3;
    localparam logic [2:0] OP_REM_BACK  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Pointer update selects
    typedef logic [2:0] ptr_op_t;
    localparam ptr_op_t PTR_HOLD  = 3'd0;
    localparam ptr_op_t PTR_COUNT = 3'd1;
    localparam ptr_op_t PTR_ZERO  = 3'd2;
    localparam ptr_op_t PTR_DEC   = 3'd3;
    localparam ptr_op_t PTR_INC   = 3'd4;

    // Memory read address selects
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_PTR_DN = 2'd0;
    localparam rd_sel_t RD_PTR_UP = 2'd1;
    localparam rd_sel_t RD_FRONT  = 2'd2;
    localparam rd_sel_t RD_BACK   = 2'd3;

    // Memory write source selects
    typedef logic wr_sel_t;
    localparam wr_sel_t WR_SHIFT = 1'b0;
    localparam wr_sel_t WR_NEW   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    chk;
        ptr_op_t ptr_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cap;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    finish;
    } ple_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ins_ok;
        logic append;
        logic front_ok;
        logic back_ok;
        logic single;
        logic dn_done;
        logic up_done;
    } ple_sts_t;

endpackage

// ===== rtl/ple_ctrl.sv =====
// Sequencer for the positional list engine: walks each request through
// check, element shifting, write-back and result. Depends on ple_pkg.
module ple_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ple_pkg::ple_sts_t sts,
    output ple_pkg::ple_cmd_t cmd,
    output logic             busy
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_MOVE_RD   = 4'd2;
    localparam logic [3:0] S_MOVE_WR   = 4'd3;
    localparam logic [3:0] S_WR_NEW    = 4'd4;
    localparam logic [3:0] S_FRONT_RD  = 4'd5;
    localparam logic [3:0] S_FRONT_CAP = 4'd6;
    localparam logic [3:0] S_UP_RD     = 4'd7;
    localparam logic [3:0] S_UP_WR     = 4'd8;
    localparam logic [3:0] S_BACK_RD   = 4'd9;
    localparam logic [3:0] S_BACK_CAP  = 4'd10;
    localparam logic [3:0] S_FINISH    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = ple_pkg::PTR_HOLD;
        cmd.rd_sel = ple_pkg::RD_FRONT;
        cmd.wr_sel = ple_pkg::WR_SHIFT;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.chk = 1'b1;
                if (sts.ins_ok)
                begin
                    if (sts.append)
                    begin
                        state_next = S_WR_NEW;
                    end
                    else
                    begin
                        cmd.ptr_op = ple_pkg::PTR_COUNT;
                        state_next = S_MOVE_RD;
                    end
                end
                else if (sts.front_ok)
                begin
                    state_next = S_FRONT_RD;
                end
                else if (sts.back_ok)
                begin
                    state_next = S_BACK_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            // Tail moves back one slot, last element first
            S_MOVE_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ple_pkg::RD_PTR_DN;
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ple_pkg::WR_SHIFT;
                cmd.ptr_op = ple_pkg::PTR_DEC;
                state_next = sts.dn_done ? S_WR_NEW : S_MOVE_RD;
            end
            S_WR_NEW:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ple_pkg::WR_NEW;
                cmd.cnt_inc = 1'b1;
                state_next  = S_FINISH;
            end
            // Front removal: grab head, then pull the rest forward
            S_FRONT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ple_pkg::RD_FRONT;
                state_next = S_FRONT_CAP;
            end
            S_FRONT_CAP:
            begin
                cmd.cap    = 1'b1;
                cmd.ptr_op = ple_pkg::PTR_ZERO;
                if (sts.single)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ple_pkg::RD_PTR_UP;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ple_pkg::WR_SHIFT;
                cmd.ptr_op = ple_pkg::PTR_INC;
                if (sts.up_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            // Back removal: read tail and drop it
            S_BACK_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ple_pkg::RD_BACK;
                state_next = S_BACK_CAP;
            end
            S_BACK_CAP:
            begin
                cmd.cap     = 1'b1;
                cmd.cnt_dec = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ple_datapath.sv =====
// Datapath of the positional list engine: element memory, count, pointer,
// request latch and result registers. Depends on ple_pkg.
module ple_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ple_pkg::ple_cmd_t                 cmd,
    output ple_pkg::ple_sts_t                 sts,
    input  logic [2:0]                        opcode,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    input  logic [6:0]                        position,
    output logic                              done,
    output logic signed [ple_pkg::DATA_W-1:0] removed_value,
    output logic [1:0]                        status,
    output logic [ple_pkg::CNT_W-1:0]         length
);

    localparam int CW = ple_pkg::CNT_W;
    localparam int AW = ple_pkg::ADDR_W;
    localparam int DW = ple_pkg::DATA_W;

    logic [DW-1:0] list_mem [ple_pkg::DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [2:0]    op_reg;
    logic [DW-1:0] value_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] removed_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          done_reg;
    logic [DW-1:0] res_value_reg;
    logic [1:0]    res_status_reg;
    logic [CW-1:0] res_length_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          is_ins;
    logic          bad_pos;
    logic          is_full;
    logic          is_empty;

    // Target index of an insert, taken against the length at accept time
    always_comb
    begin
        case (opcode)
            ple_pkg::OP_INS_FRONT: idx_next = '0;
            ple_pkg::OP_INS_BACK:  idx_next = count_reg;
            default:               idx_next = CW'(position);
        endcase
    end

    // Request checks on the latched beat
    always_comb
    begin
        is_ins   = op_reg inside {ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK,
                                  ple_pkg::OP_INS_POS};
        bad_pos  = is_ins && (idx_reg > count_reg);
        is_full  = (count_reg == CW'(ple_pkg::DEPTH));
        is_empty = (count_reg == '0);

        sts.ins_ok   = is_ins && !bad_pos && !is_full;
        sts.append   = (idx_reg == count_reg);
        sts.front_ok = (op_reg == ple_pkg::OP_REM_FRONT) && !is_empty;
        sts.back_ok  = (op_reg == ple_pkg::OP_REM_BACK) && !is_empty;
        sts.single   = (count_reg == CW'(1));
        sts.dn_done  = (CW'(ptr_reg) == idx_reg + CW'(1));
        sts.up_done  = (CW'(ptr_reg) + CW'(2) == count_reg);

        if (bad_pos)
        begin
            status_next = ple_pkg::ST_BADPOS;
        end
        else if (is_ins && is_full)
        begin
            status_next = ple_pkg::ST_FULL;
        end
        else if ((op_reg == ple_pkg::OP_REM_FRONT || op_reg == ple_pkg::OP_REM_BACK)
                 && is_empty)
        begin
            status_next = ple_pkg::ST_EMPTY;
        end
        else
        begin
            status_next = ple_pkg::ST_OK;
        end
    end

    // Pointer and count updates
    always_comb
    begin
        case (cmd.ptr_op)
            ple_pkg::PTR_COUNT: ptr_next = AW'(count_reg);
            ple_pkg::PTR_ZERO:  ptr_next = '0;
            ple_pkg::PTR_DEC:   ptr_next = ptr_reg - AW'(1);
            ple_pkg::PTR_INC:   ptr_next = ptr_reg + AW'(1);
            default:            ptr_next = ptr_reg;
        endcase

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Memory address and data muxing
    always_comb
    begin
        case (cmd.rd_sel)
            ple_pkg::RD_PTR_DN: rd_addr = ptr_reg - AW'(1);
            ple_pkg::RD_PTR_UP: rd_addr = ptr_reg + AW'(1);
            ple_pkg::RD_BACK:   rd_addr = AW'(count_reg - CW'(1));
            default:            rd_addr = '0;
        endcase
        wr_addr = (cmd.wr_sel == ple_pkg::WR_NEW) ? idx_reg[AW-1:0] : ptr_reg;
        wr_data = (cmd.wr_sel == ple_pkg::WR_NEW) ? value_reg : rd_data_reg;
    end

    // Element memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            list_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    // Request latch, pointer and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            op_reg      <= opcode;
            value_reg   <= value;
            idx_reg     <= idx_next;
            removed_reg <= '0;
        end
        if (cmd.chk)
        begin
            status_reg <= status_next;
        end
        if (cmd.cap)
        begin
            removed_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            res_value_reg  <= removed_reg;
            res_status_reg <= status_reg;
            res_length_reg <= count_reg;
        end
    end

    assign done          = done_reg;
    assign removed_value = res_value_reg;
    assign status        = res_status_reg;
    assign length        = res_length_reg;

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// Top level of the positional list engine: joins the sequencer and the
// datapath. Depends on ple_pkg, ple_ctrl and ple_datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  request   | start & !busy          | opcode, value, position
//  result    | done (one-cycle pulse) | removed_value, status, length
//
// A rejected or unused request goes straight from check to result; a back
// removal reads the tail and captures it; a front removal captures the
// head, then moves the rest forward; an insert at pos into n elements
// moves the elements from pos on back one slot, then writes the new value
// (a back insert is pos = n and moves none). The element memory moves one
// element at a time (read, then write). busy drops with the done pulse, so
// the next request can be taken at the edge that takes the result. Reset
// empties the list at once; the receiver cannot hold off the result pulse.
module positional_list_engine_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        opcode,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    input  logic [6:0]                        position,
    output logic                              done,
    output logic signed [ple_pkg::DATA_W-1:0] removed_value,
    output logic [1:0]                        status,
    output logic [ple_pkg::CNT_W-1:0]         length
);

    ple_pkg::ple_cmd_t cmd;
    ple_pkg::ple_sts_t sts;

    ple_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ple_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .length        (length)
    );

endmodule

// ===== sim/positional_list_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine_core: scoreboard class with its own
// list model, directed corner requests, then phased random traffic. Depends on ple_pkg.
module positional_list_engine_core_tb;

    // Expected contents of one result beat
    typedef struct {
        logic signed [ple_pkg::DATA_W-1:0] removed;
        logic [1:0]                        status;
        logic [ple_pkg::CNT_W-1:0]         length;
    } list_result_t;

    // Scoreboard: mirrors the list and queues one expected result per request
    class list_scoreboard;
        logic signed [ple_pkg::DATA_W-1:0] cells[$];
        list_result_t                      awaited[$];
        int unsigned                       mismatches;
        int unsigned                       n_accepted, n_checked, n_inserted, n_removed;
        int unsigned                       n_full, n_empty, n_badpos, n_unused, peak;

        function new();
            mismatches = 0;
            n_accepted = 0;
            n_checked  = 0;
            n_inserted = 0;
            n_removed  = 0;
            n_full     = 0;
            n_empty    = 0;
            n_badpos   = 0;
            n_unused   = 0;
            peak       = 0;
        endfunction

        function int unsigned fill_level();
            return cells.size();
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Update the list model for an accepted request and queue its result
        function void note_request(logic [2:0] op, logic signed [ple_pkg::DATA_W-1:0] val,
                                   logic [6:0] pos);
            list_result_t r;
            int unsigned  idx;
            r.removed = '0;
            r.status  = ple_pkg::ST_OK;
            n_accepted++;
            case (op)
                ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_POS:
                begin
                    if (op == ple_pkg::OP_INS_FRONT)
                        idx = 0;
                    else if (op == ple_pkg::OP_INS_BACK)
                        idx = cells.size();
                    else
                        idx = pos;
                    // position check wins over the full check
                    if (idx > cells.size())
                        r.status = ple_pkg::ST_BADPOS;
                    else if (cells.size() >= ple_pkg::DEPTH)
                        r.status = ple_pkg::ST_FULL;
                    else
                    begin
                        cells.insert(idx, val);
                        n_inserted++;
                    end
                end
                ple_pkg::OP_REM_FRONT:
                begin
                    if (cells.size() == 0)
                        r.status = ple_pkg::ST_EMPTY;
                    else
                    begin
                        r.removed = cells.pop_front();
                        n_removed++;
                    end
                end
                ple_pkg::OP_REM_BACK:
                begin
                    if (cells.size() == 0)
                        r.status = ple_pkg::ST_EMPTY;
                    else
                    begin
                        r.removed = cells.pop_back();
                        n_removed++;
                    end
                end
                default:
                    n_unused++;
            endcase
            r.length = ple_pkg::CNT_W'(cells.size());
            if (r.status == ple_pkg::ST_FULL)   n_full++;
            if (r.status == ple_pkg::ST_EMPTY)  n_empty++;
            if (r.status == ple_pkg::ST_BADPOS) n_badpos++;
            if (cells.size() > peak)            peak = cells.size();
            awaited.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(logic signed [ple_pkg::DATA_W-1:0] rv, logic [1:0] st,
                                   logic [ple_pkg::CNT_W-1:0] len);
            list_result_t e;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat removed=%0d status=%0d length=%0d",
                             $realtime, rv, st, len);
                return;
            end
            e = awaited.pop_front();
            n_checked++;
            if (rv !== e.removed || st !== e.status || len !== e.length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d mismatch: removed %0d/%0d",
                             $realtime, n_checked, e.removed, rv,
                             " status %0d/%0d length %0d/%0d (exp/act)",
                             e.status, st, e.length, len);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [2:0]                        opcode;
    logic signed [ple_pkg::DATA_W-1:0] value;
    logic [6:0]                        position;
    logic                              done;
    logic signed [ple_pkg::DATA_W-1:0] removed_value;
    logic [1:0]                        status;
    logic [ple_pkg::CNT_W-1:0]         length;

    list_scoreboard sb;

    positional_list_engine_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .length        (length)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result monitor: every done pulse is one beat
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(removed_value, status, length);
    end

    // Present one request and hold it until the block takes it
    task automatic issue(input logic [2:0] op, input logic signed [ple_pkg::DATA_W-1:0] val,
                         input logic [6:0] pos);
        start    <= 1'b1;
        opcode   <= op;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_request(op, val, pos);
    endtask

    // Random sender gap, about 21 in a hundred requests
    task automatic maybe_idle(input bit quiet);
        int unsigned n;
        if (!quiet && $urandom_range(99) < 21)
        begin
            n = $urandom_range(12, 1);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Corner cases: empty removals, bad positions, only-element removal,
    // append via position equal to length, middle insert, unused opcodes
    task automatic run_directed();
        maybe_idle(0); issue(ple_pkg::OP_REM_FRONT, 32'sd7, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_REM_BACK, 32'sd9, 7'd127);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'sd1, 7'd1);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'sd2, 7'd127);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'h7FFF_FFFF, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_REM_FRONT, 32'sd0, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_INS_BACK, 32'h8000_0000, 7'd5);
        maybe_idle(0); issue(ple_pkg::OP_REM_BACK, 32'sd0, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_INS_FRONT, -32'sd1, 7'd64);
        maybe_idle(0); issue(ple_pkg::OP_INS_BACK, 32'sd5, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'sd100, 7'd2);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'sd200, 7'd1);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'h8000_0000, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_INS_POS, 32'sd3, 7'd64);
        maybe_idle(0); issue(3'd5, 32'h7FFF_FFFF, 7'd127);
        maybe_idle(0); issue(3'd6, 32'sd0, 7'd0);
        maybe_idle(0); issue(3'd7, -32'sd1, 7'd64);
        maybe_idle(0); issue(ple_pkg::OP_REM_FRONT, 32'sd0, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_REM_BACK, 32'sd0, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_INS_FRONT, 32'h7FFF_FFFF, 7'd0);
        maybe_idle(0); issue(ple_pkg::OP_REM_BACK, 32'sd0, 7'd0);
    endtask

    // Phased random traffic: grow phases push the list toward full, shrink phases
    // toward empty, balanced phases mix; a few unused opcodes and bad positions
    task automatic run_random(input int unsigned n_items);
        int unsigned                       k, fill, phase_left, pick;
        int unsigned                       phase_kind;
        logic [2:0]                        op;
        logic [6:0]                        pos;
        logic signed [ple_pkg::DATA_W-1:0] val;
        phase_left = 0;
        phase_kind = 0;
        for (k = 0; k < n_items; k++)
        begin
            if (phase_left == 0)
            begin
                phase_kind = $urandom_range(2);
                phase_left = $urandom_range(150, 40);
            end
            phase_left--;
            fill = sb.fill_level();
            pick = $urandom_range(99);
            if (pick < 3)
                op = 3'($urandom_range(7, 5));
            else if ((phase_kind == 0 && pick < 80) || (phase_kind == 1 && pick < 25) ||
                     (phase_kind == 2 && pick < 55))
            begin
                case ($urandom_range(2))
                    0:       op = ple_pkg::OP_INS_FRONT;
                    1:       op = ple_pkg::OP_INS_BACK;
                    default: op = ple_pkg::OP_INS_POS;
                endcase
            end
            else
                op = $urandom_range(1) ? ple_pkg::OP_REM_FRONT : ple_pkg::OP_REM_BACK;
            if (op == ple_pkg::OP_INS_POS && $urandom_range(99) < 85)
                pos = 7'($urandom_range(fill));
            else
                pos = 7'($urandom());
            case ($urandom_range(9))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = ple_pkg::DATA_W'($urandom_range(15));
                default: val = $urandom();
            endcase
            // long stretch with back-to-back requests
            maybe_idle(k >= 700 && k < 1000);
            issue(op, val, pos);
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        opcode   = ple_pkg::OP_INS_FRONT;
        value    = '0;
        position = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(1750);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        $display("Covered %0d requests: %0d inserts, %0d removals,",
                 sb.n_accepted, sb.n_inserted, sb.n_removed,
                 " %0d unused opcodes, peak length %0d.", sb.n_unused, sb.peak);
        $display("Rejections seen: %0d full, %0d empty, %0d bad position; %0d mismatches.",
                 sb.n_full, sb.n_empty, sb.n_badpos, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("positional_list_engine_core_tb OK");
        else
            $display("positional_list_engine_core_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("Timeout with %0d results outstanding", sb.outstanding());
        $display("positional_list_engine_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_datapath.sv
rtl/positional_list_engine_core.sv
sim/positional_list_engine_core_tb.sv
